### rtl/core/spq_pkg.sv
// ============================================================================
// spq_pkg: shared types and codes for the stable priority queue
// Entry layout, operation codes, result status codes and input stream field layout.
// ============================================================================
package spq_pkg;

    localparam int ItemW  = 16;
    localparam int KindW  = 8;
    localparam int PrioW  = 16;
    localparam int StatW  = 3;
    localparam int CountW = 5;

    localparam int SDataW = 48;
    localparam int MDataW = 48;

    // input item field offsets inside s_tdata
    localparam int OpLo   = 0;
    localparam int ItemLo = 1;
    localparam int KindLo = ItemLo + ItemW;
    localparam int PrioLo = KindLo + KindW;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [StatW-1:0] STAT_OK    = 3'd0;
    localparam logic [StatW-1:0] STAT_NULL  = 3'd1;
    localparam logic [StatW-1:0] STAT_DUP   = 3'd2;
    localparam logic [StatW-1:0] STAT_FULL  = 3'd3;
    localparam logic [StatW-1:0] STAT_EMPTY = 3'd4;

    localparam logic [ItemW-1:0] NULL_ITEM = '0;

    typedef struct packed {
        logic signed [PrioW-1:0] prio;
        logic [KindW-1:0]        kind;
        logic [ItemW-1:0]        item;
    } spq_entry_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_PLACE  = 6'b001000,
        S_PULL   = 6'b010000,
        S_FINISH = 6'b100000
    } spq_state_t;

    // lower priority value leaves first; ties keep arrival order
    function automatic logic prio_le(input logic signed [PrioW-1:0] a,
                                     input logic signed [PrioW-1:0] b);
        return (a <= b);
    endfunction

endpackage

### rtl/core/stable_priority_queue_unit.sv
// ============================================================================
// stable_priority_queue_unit: bounded, stable priority queue
// Sorted entry store in a single-port-write, single-port-read memory, worked
// one entry per cycle by a small sequencer around one read and compare path.
// ============================================================================
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, results leave on
//   m_tvalid/m_tready/m_tdata; each input item gives exactly one result item.
//   An insert checks for a null handle, scans all entries for a duplicate
//   handle while counting entries of lower or equal priority, checks for a
//   full store, then moves the entries behind the insertion point up by one
//   slot and writes the new entry. A remove reads the front entry and moves
//   every other entry down by one slot.
//   Scan, shift and pull run at the pace of the memory read port: one entry read per cycle.
//   s_tready is high only while the sequencer is idle, so one item is at work
//   at a time; a finished result waits in the output register while the next
//   item is already accepted and worked.
//   If m_tready stays low, the sequencer holds its next result until the
//   output register is free. Reset empties the queue at once (fill count
//   cleared); the entry memory needs no clearing pass.
// ============================================================================
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // [0] op, [16:1] item_id, [24:17] kind, [40:25] priority_req, [47:41] zero
    input  logic [SDataW-1:0] s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // [2:0] status, [7:3] count, [23:8] out_item, [31:24] out_kind,
    // [47:32] out_priority
    output logic [MDataW-1:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCnt = CW'(CAPACITY);

    // entry store
    spq_entry_t slot_mem [CAPACITY];
    spq_entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    spq_entry_t    wr_data;

    // control state
    spq_state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          vld_reg, vld_next;     // rd_data_reg holds a fresh entry
    logic          m_tvalid_reg, m_tvalid_next;

    // working registers
    logic [CW-1:0] idx_reg, idx_next;     // read issue counter
    logic [CW-1:0] src_reg, src_next;     // slot held in rd_data_reg
    logic [CW-1:0] pos_reg, pos_next;     // insertion point
    logic          dup_reg, dup_next;
    spq_entry_t    req_reg, req_next;
    logic [StatW-1:0] res_status_reg, res_status_next;
    spq_entry_t    res_entry_reg, res_entry_next;
    logic [MDataW-1:0] m_tdata_reg, m_tdata_next;

    logic [CW-1:0] idx_dec;
    logic [CW-1:0] src_inc;
    logic [CW-1:0] src_dec;
    spq_entry_t    s_entry;
    logic          s_op;

    assign idx_dec = idx_reg - 1'b1;
    assign src_inc = src_reg + 1'b1;
    assign src_dec = src_reg - 1'b1;

    assign s_op          = s_tdata[OpLo];
    assign s_entry.item  = s_tdata[ItemLo +: ItemW];
    assign s_entry.kind  = s_tdata[KindLo +: KindW];
    assign s_entry.prio  = s_tdata[PrioLo +: PrioW];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        vld_next        = 1'b0;
        idx_next        = idx_reg;
        src_next        = src_reg;
        pos_next        = pos_reg;
        dup_next        = dup_reg;
        req_next        = req_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg;
        rd_addr         = idx_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = src_inc[AW-1:0];
        wr_data         = rd_data_reg;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next       = s_entry;
                    idx_next       = '0;
                    pos_next       = '0;
                    dup_next       = 1'b0;
                    res_entry_next = '0;
                    if (s_op == OP_INSERT) begin
                        if (s_entry.item == NULL_ITEM) begin
                            res_status_next = STAT_NULL;
                            state_next      = S_FINISH;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (fill_reg == '0) begin
                            res_status_next = STAT_EMPTY;
                            state_next      = S_FINISH;
                        end else begin
                            state_next = S_PULL;
                        end
                    end
                end
            end

            S_SCAN: begin
                // read every entry in turn: look for the handle, count
                // entries that stay ahead of the new one
                if (idx_reg != fill_reg) begin
                    vld_next = 1'b1;
                    src_next = idx_reg;
                    idx_next = idx_reg + 1'b1;
                end
                if (vld_reg) begin
                    if (rd_data_reg.item == req_reg.item) begin
                        dup_next = 1'b1;
                    end
                    if (prio_le(rd_data_reg.prio, req_reg.prio)) begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                if ((idx_reg == fill_reg) && !vld_reg) begin
                    if (dup_reg) begin
                        res_status_next = STAT_DUP;
                        state_next      = S_FINISH;
                    end else if (fill_reg == CapCnt) begin
                        res_status_next = STAT_FULL;
                        state_next      = S_FINISH;
                    end else if (pos_reg == fill_reg) begin
                        state_next = S_PLACE;
                    end else begin
                        idx_next   = fill_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // move entries from the tail down to pos up by one slot
                rd_addr = idx_dec[AW-1:0];
                if (idx_reg != pos_reg) begin
                    vld_next = 1'b1;
                    src_next = idx_dec;
                    idx_next = idx_dec;
                end
                if (vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = src_inc[AW-1:0];
                    wr_data = rd_data_reg;
                end
                if ((idx_reg == pos_reg) && !vld_reg) begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE: begin
                wr_en           = 1'b1;
                wr_addr         = pos_reg[AW-1:0];
                wr_data         = req_reg;
                fill_next       = fill_reg + 1'b1;
                res_status_next = STAT_OK;
                state_next      = S_FINISH;
            end

            S_PULL: begin
                // take the front entry, move the rest down by one slot
                if (idx_reg != fill_reg) begin
                    vld_next = 1'b1;
                    src_next = idx_reg;
                    idx_next = idx_reg + 1'b1;
                end
                if (vld_reg) begin
                    if (src_reg == '0) begin
                        res_entry_next = rd_data_reg;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = src_dec[AW-1:0];
                        wr_data = rd_data_reg;
                    end
                end
                if ((idx_reg == fill_reg) && !vld_reg) begin
                    fill_next       = fill_reg - 1'b1;
                    res_status_next = STAT_OK;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_entry_reg, CountW'(fill_reg), res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            vld_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            vld_reg      <= vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        src_reg        <= src_next;
        pos_reg        <= pos_next;
        dup_reg        <= dup_next;
        req_reg        <= req_next;
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
